### hw/rtl/ble_pkg.sv
// ----------------------------------------------------------------------------
// Battery level estimator package
// Shared widths, codes, register defaults and the discharge curve table.
// ----------------------------------------------------------------------------
`default_nettype none

package ble_pkg;

   // Discharge curve size, clamped to the range the table supports.
   localparam int TablePoints = 10;
   localparam int PointCount  = (TablePoints < 2) ? 2 :
                                (TablePoints > 32) ? 32 : TablePoints;

   // Field and datapath widths.
   localparam int PIN_W      = 12;
   localparam int MV_W       = 15;
   localparam int PCT_W      = 7;
   localparam int STATE_W    = 2;
   localparam int ALPHA_W    = 16;
   localparam int SCALE_W    = 15;
   localparam int ROM_MV_W   = 14;
   localparam int ROM_IDX_W  = 5;
   localparam int Q16_W      = 31;
   localparam int FRAC_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int MUL_A_W    = 32;
   localparam int MUL_B_W    = 18;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int NUM_W      = 21;
   localparam int QUO_W      = 7;
   localparam int BIT_W      = 3;

   // Request function codes.
   localparam logic FUNC_UPDATE = 1'b0;
   localparam logic FUNC_SEED   = 1'b1;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_EMA_ALPHA  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIV_SCALE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_LEVEL  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CRIT_LEVEL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RISE_MARGIN = 3'd4;

   // Register reset values.
   localparam logic [ALPHA_W-1:0] ALPHA_RESET  = 16'd3277;
   localparam logic [SCALE_W-1:0] SCALE_RESET  = 15'd16384;
   localparam logic [MV_W-1:0]    LOW_RESET    = 15'd6500;
   localparam logic [MV_W-1:0]    CRIT_RESET   = 15'd6000;
   localparam logic [PCT_W-1:0]   MARGIN_RESET = 7'd2;

   // Filter and level reset values.
   localparam logic [MV_W-1:0]  FILTER_RESET_MV = 15'd8400;
   localparam logic [PCT_W-1:0] PCT_FULL        = 7'd100;
   localparam logic [PCT_W-1:0] PCT_EMPTY       = 7'd0;

   // Rounding constant for the Q16 filter update.
   localparam logic signed [PROD_W-1:0] ROUND_HALF = 50'sd32768;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_FILTER,
      ST_ACCUM,
      ST_LOOKUP,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   typedef enum logic [STATE_W-1:0] {
      CHG_NORMAL   = 2'd0,
      CHG_LOW      = 2'd1,
      CHG_CRITICAL = 2'd2
   } charge_type;

   typedef struct packed {
      logic [ROM_MV_W-1:0] mv;
      logic [PCT_W-1:0]    pct;
   } gauge_point_type;

   // Outcome of the table lookup for one filtered voltage.
   typedef struct packed {
      logic             direct;
      logic [PCT_W-1:0] direct_pct;
      logic [PCT_W-1:0] plo;
   } lookup_type;

   // Discharge curve: millivolts falling, percentage falling.
   function automatic gauge_point_type gauge_rom(input logic [ROM_IDX_W-1:0] idx);
      gauge_point_type pt;
      case (idx)
         5'd0:    pt = '{mv: 14'd8400, pct: 7'd100};
         5'd1:    pt = '{mv: 14'd8200, pct: 7'd95};
         5'd2:    pt = '{mv: 14'd8000, pct: 7'd90};
         5'd3:    pt = '{mv: 14'd7800, pct: 7'd80};
         5'd4:    pt = '{mv: 14'd7600, pct: 7'd70};
         5'd5:    pt = '{mv: 14'd7400, pct: 7'd50};
         5'd6:    pt = '{mv: 14'd7200, pct: 7'd30};
         5'd7:    pt = '{mv: 14'd7000, pct: 7'd15};
         5'd8:    pt = '{mv: 14'd6500, pct: 7'd5};
         default: pt = '{mv: 14'd6000, pct: 7'd0};
      endcase
      return pt;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/ble_if.sv
// ----------------------------------------------------------------------------
// Battery level estimator channels
// Valid/ready interfaces for requests, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

// Request channel: one pin sample and its function code.
interface ble_req_if;
   logic                     valid;
   logic                     ready;
   logic                     func;
   logic [ble_pkg::PIN_W-1:0] pin_mv;

   modport source (output valid, output func, output pin_mv, input ready);
   modport sink   (input valid, input func, input pin_mv, output ready);
endinterface

// Result channel: reported level, filtered voltage and charge state.
interface ble_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [ble_pkg::PCT_W-1:0]   level_pct;
   logic [ble_pkg::MV_W-1:0]    filtered_mv;
   logic [ble_pkg::STATE_W-1:0] charge_state;

   modport source (output valid, output level_pct, output filtered_mv,
                   output charge_state, input ready);
   modport sink   (input valid, input level_pct, input filtered_mv,
                   input charge_state, output ready);
endinterface

// Register write channel.
interface ble_csr_if;
   logic                          valid;
   logic                          ready;
   logic [ble_pkg::CSR_IDX_W-1:0]  index;
   logic [ble_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/battery_level_estimator_core.sv
// ----------------------------------------------------------------------------
// Battery level estimator core
// Scales a pin sample to pack millivolts, filters it, maps it to a
// percentage over the discharge curve and classifies the charge state.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Contents
//   req_chan   in         func, pin_mv
//   rsp_chan   out        level_pct, filtered_mv, charge_state
//   csr_chan   in         index, data (register write, always ready)
//
// An update request passes the scale, filter, accumulate, lookup, divide and
// final steps until the block is ready again; a seed request skips the
// accumulate step. The steps follow from the single shared multiplier (scale,
// filter and interpolation products in turn) and the seven-step restoring quotient loop.
// Reset is synchronous; it restores the registers, the filter to 8400 mV and
// the level to 100. A stalled result holds in its output register while the
// block stays ready for the next request; only the final step waits for it.
//
`default_nettype none

module battery_level_estimator_core (
   input  wire           clock,
   input  wire           reset,
   ble_req_if.sink       req_chan,
   ble_rsp_if.source     rsp_chan,
   ble_csr_if.sink       csr_chan
);

   // Configuration registers.
   logic [ble_pkg::ALPHA_W-1:0] alpha_ff;
   logic [ble_pkg::SCALE_W-1:0] scale_ff;
   logic [ble_pkg::MV_W-1:0]    low_ff;
   logic [ble_pkg::MV_W-1:0]    crit_ff;
   logic [ble_pkg::PCT_W-1:0]   margin_ff;

   // Sequencer and working registers.
   ble_pkg::state_type state_ff, state_in;
   logic                          func_ff;
   logic [ble_pkg::PIN_W-1:0]     pin_ff;
   logic [ble_pkg::Q16_W-1:0]     filt_ff, filt_in;
   logic [ble_pkg::PCT_W-1:0]     level_ff;
   logic signed [ble_pkg::PROD_W-1:0] prod_ff;
   ble_pkg::lookup_type           look_ff, look_in;
   logic [ble_pkg::ROM_MV_W-1:0]  div_ff, div_in;
   logic [ble_pkg::NUM_W-1:0]     rem_ff, rem_in;
   logic [ble_pkg::QUO_W-1:0]     quo_ff;
   logic [ble_pkg::BIT_W-1:0]     bit_ff;
   logic                          quo_bit;

   // Result register.
   logic                          rsp_valid_ff;
   logic [ble_pkg::PCT_W-1:0]     rsp_level_ff;
   logic [ble_pkg::MV_W-1:0]      rsp_mv_ff;
   ble_pkg::charge_type           rsp_state_ff;

   // Sequencer outputs.
   logic en_accept, en_scale, en_filter, en_accum, en_lookup, en_divide;
   logic fin_fire, rsp_free;

   // Shared multiplier.
   logic signed [ble_pkg::MUL_A_W-1:0] mul_a;
   logic signed [ble_pkg::MUL_B_W-1:0] mul_b;
   logic signed [ble_pkg::PROD_W-1:0]  mul_p;

   // Pack voltage and filter terms.
   logic [ble_pkg::Q16_W-1:0]          inst_q16;
   logic signed [ble_pkg::MUL_A_W-1:0] diff_q16;
   logic signed [ble_pkg::PROD_W-1:0]  round_q16;

   // Table lookup terms.
   logic [ble_pkg::MV_W-1:0]     cur_mv;
   ble_pkg::gauge_point_type     first_pt, last_pt, seg_hi, seg_lo, pt_hi, pt_lo;
   logic                         seg_found;
   logic [ble_pkg::ROM_MV_W-1:0] seg_dv;
   logic [ble_pkg::PCT_W-1:0]    seg_dp;

   // Division and result terms.
   logic [ble_pkg::NUM_W-1:0] rem_cur, div_shift;
   logic [ble_pkg::PCT_W:0]   pct_sum, level_limit;
   logic [ble_pkg::PCT_W-1:0] pct_fin, level_in;
   ble_pkg::charge_type       charge_in;

   // Channel handshakes.
   assign req_chan.ready = (state_ff == ble_pkg::ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.level_pct    = rsp_level_ff;
   assign rsp_chan.filtered_mv  = rsp_mv_ff;
   assign rsp_chan.charge_state = rsp_state_ff;

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ble_pkg::ST_IDLE: begin
            if (req_chan.valid) state_in = ble_pkg::ST_SCALE;
         end
         ble_pkg::ST_SCALE:  state_in = ble_pkg::ST_FILTER;
         ble_pkg::ST_FILTER: begin
            state_in = (func_ff == ble_pkg::FUNC_SEED) ? ble_pkg::ST_LOOKUP
                                                      : ble_pkg::ST_ACCUM;
         end
         ble_pkg::ST_ACCUM:  state_in = ble_pkg::ST_LOOKUP;
         ble_pkg::ST_LOOKUP: state_in = ble_pkg::ST_DIVIDE;
         ble_pkg::ST_DIVIDE: begin
            if (bit_ff == '0) state_in = ble_pkg::ST_FINISH;
         end
         ble_pkg::ST_FINISH: begin
            if (rsp_free) state_in = ble_pkg::ST_IDLE;
         end
         default: state_in = ble_pkg::ST_IDLE;
      endcase
   end

   // Step enables and multiplier operand selection.
   always_comb begin
      en_accept = 1'b0;
      en_scale  = 1'b0;
      en_filter = 1'b0;
      en_accum  = 1'b0;
      en_lookup = 1'b0;
      en_divide = 1'b0;
      fin_fire  = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         ble_pkg::ST_IDLE: en_accept = req_chan.valid;
         ble_pkg::ST_SCALE: begin
            en_scale = 1'b1;
            mul_a    = $signed(ble_pkg::MUL_A_W'(pin_ff));
            mul_b    = $signed(ble_pkg::MUL_B_W'(scale_ff));
         end
         ble_pkg::ST_FILTER: begin
            en_filter = 1'b1;
            mul_a     = diff_q16;
            mul_b     = $signed(ble_pkg::MUL_B_W'(alpha_ff));
         end
         ble_pkg::ST_ACCUM: en_accum = 1'b1;
         ble_pkg::ST_LOOKUP: begin
            en_lookup = 1'b1;
            mul_a     = $signed(ble_pkg::MUL_A_W'(seg_dv));
            mul_b     = $signed(ble_pkg::MUL_B_W'(seg_dp));
         end
         ble_pkg::ST_DIVIDE: en_divide = 1'b1;
         ble_pkg::ST_FINISH: fin_fire  = rsp_free;
         default: ;
      endcase
   end

   assign mul_p = ble_pkg::PROD_W'(mul_a) * ble_pkg::PROD_W'(mul_b);

   // Pack voltage in Q16 from the scale product, and the filter step.
   assign inst_q16  = {prod_ff[26:0], 4'b0000};
   assign diff_q16  = $signed({1'b0, inst_q16}) - $signed({1'b0, filt_ff});
   assign round_q16 = (prod_ff + ble_pkg::ROUND_HALF) >>> ble_pkg::FRAC_W;

   always_comb begin
      filt_in = filt_ff;
      if (en_filter && func_ff == ble_pkg::FUNC_SEED) begin
         filt_in = inst_q16;
      end else if (en_accum) begin
         filt_in = filt_ff + round_q16[ble_pkg::Q16_W-1:0];
      end
   end

   // Segment search over the discharge curve; the matching segment with the lowest table index wins.
   assign cur_mv   = filt_ff[ble_pkg::Q16_W-1:ble_pkg::FRAC_W];
   assign first_pt = ble_pkg::gauge_rom('0);
   assign last_pt  = ble_pkg::gauge_rom(ble_pkg::ROM_IDX_W'(ble_pkg::PointCount - 1));

   always_comb begin
      seg_found = 1'b0;
      seg_hi    = last_pt;
      seg_lo    = last_pt;
      for (int i = ble_pkg::PointCount - 2; i >= 0; i--) begin
         pt_hi = ble_pkg::gauge_rom(ble_pkg::ROM_IDX_W'(i));
         pt_lo = ble_pkg::gauge_rom(ble_pkg::ROM_IDX_W'(i + 1));
         if (cur_mv <= {1'b0, pt_hi.mv} && cur_mv >= {1'b0, pt_lo.mv}) begin
            seg_found = 1'b1;
            seg_hi    = pt_hi;
            seg_lo    = pt_lo;
         end
      end
   end

   assign seg_dv = ble_pkg::ROM_MV_W'(cur_mv) - seg_lo.mv;
   assign seg_dp = seg_hi.pct - seg_lo.pct;

   // Lookup outcome: saturated ends, flat or rising segments, or interpolation.
   always_comb begin
      look_in.direct     = 1'b1;
      look_in.direct_pct = ble_pkg::PCT_EMPTY;
      look_in.plo        = seg_lo.pct;
      div_in             = seg_hi.mv - seg_lo.mv;
      if (cur_mv >= {1'b0, first_pt.mv}) begin
         look_in.direct_pct = ble_pkg::PCT_FULL;
      end else if (cur_mv <= {1'b0, last_pt.mv} || !seg_found) begin
         look_in.direct_pct = ble_pkg::PCT_EMPTY;
      end else if (seg_hi.mv == seg_lo.mv || seg_hi.pct < seg_lo.pct) begin
         look_in.direct_pct = (seg_lo.pct > ble_pkg::PCT_FULL) ? ble_pkg::PCT_FULL
                                                              : seg_lo.pct;
      end else begin
         look_in.direct = 1'b0;
      end
   end

   // One restoring quotient bit per cycle; the numerator comes from the multiplier.
   assign rem_cur   = (bit_ff == ble_pkg::BIT_W'(ble_pkg::QUO_W - 1))
                      ? prod_ff[ble_pkg::NUM_W-1:0] : rem_ff;
   assign div_shift = ble_pkg::NUM_W'(div_ff) << bit_ff;
   assign quo_bit   = (rem_cur >= div_shift);
   assign rem_in    = quo_bit ? (rem_cur - div_shift) : rem_cur;

   // Final percentage, hysteresis and charge state.
   assign pct_sum     = {1'b0, look_ff.plo} + {1'b0, quo_ff};
   assign pct_fin     = look_ff.direct ? look_ff.direct_pct :
                        (pct_sum > {1'b0, ble_pkg::PCT_FULL}) ? ble_pkg::PCT_FULL
                                                             : pct_sum[ble_pkg::PCT_W-1:0];
   assign level_limit = {1'b0, level_ff} + {1'b0, margin_ff};

   always_comb begin
      level_in = level_ff;
      if (func_ff == ble_pkg::FUNC_SEED || pct_fin < level_ff ||
          {1'b0, pct_fin} > level_limit) begin
         level_in = pct_fin;
      end
   end

   always_comb begin
      if (filt_ff <= {crit_ff, ble_pkg::FRAC_W'(0)}) begin
         charge_in = ble_pkg::CHG_CRITICAL;
      end else if (filt_ff <= {low_ff, ble_pkg::FRAC_W'(0)}) begin
         charge_in = ble_pkg::CHG_LOW;
      end else begin
         charge_in = ble_pkg::CHG_NORMAL;
      end
   end

   // Control state: sequencer, registers, filter, level and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ble_pkg::ST_IDLE;
         alpha_ff     <= ble_pkg::ALPHA_RESET;
         scale_ff     <= ble_pkg::SCALE_RESET;
         low_ff       <= ble_pkg::LOW_RESET;
         crit_ff      <= ble_pkg::CRIT_RESET;
         margin_ff    <= ble_pkg::MARGIN_RESET;
         filt_ff      <= {ble_pkg::FILTER_RESET_MV, ble_pkg::FRAC_W'(0)};
         level_ff     <= ble_pkg::PCT_FULL;
         rsp_valid_ff <= 1'b0;
         bit_ff       <= '0;
      end else begin
         state_ff <= state_in;
         filt_ff  <= filt_in;
         if (csr_chan.valid) begin
            case (csr_chan.index)
               ble_pkg::CSR_EMA_ALPHA:   alpha_ff  <= csr_chan.data[ble_pkg::ALPHA_W-1:0];
               ble_pkg::CSR_DIV_SCALE:   scale_ff  <= csr_chan.data[ble_pkg::SCALE_W-1:0];
               ble_pkg::CSR_LOW_LEVEL:   low_ff    <= csr_chan.data[ble_pkg::MV_W-1:0];
               ble_pkg::CSR_CRIT_LEVEL:  crit_ff   <= csr_chan.data[ble_pkg::MV_W-1:0];
               ble_pkg::CSR_RISE_MARGIN: margin_ff <= csr_chan.data[ble_pkg::PCT_W-1:0];
               default: ;
            endcase
         end
         if (en_lookup) begin
            bit_ff <= ble_pkg::BIT_W'(ble_pkg::QUO_W - 1);
         end else if (en_divide && bit_ff != '0) begin
            bit_ff <= bit_ff - 1'b1;
         end
         if (fin_fire) begin
            level_ff     <= level_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (en_accept) begin
         func_ff <= req_chan.func;
         pin_ff  <= req_chan.pin_mv;
      end
      if (en_scale || en_filter || en_lookup) begin
         prod_ff <= mul_p;
      end
      if (en_lookup) begin
         look_ff <= look_in;
         div_ff  <= div_in;
         quo_ff  <= '0;
      end
      if (en_divide) begin
         rem_ff         <= rem_in;
         quo_ff[bit_ff] <= quo_bit;
      end
      if (fin_fire) begin
         rsp_level_ff <= level_in;
         rsp_mv_ff    <= cur_mv;
         rsp_state_ff <= charge_in;
      end
   end

   // An accepted request always starts with the scale product.
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> state_ff == ble_pkg::ST_SCALE)
      else $error("accepted request did not enter the scale step");

   // The filter accumulate step only follows a filter multiply.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ble_pkg::ST_ACCUM |-> $past(state_ff) == ble_pkg::ST_FILTER)
      else $error("accumulate step entered out of order");

   // A new result appears only out of the final step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ble_pkg::ST_FINISH)
      else $error("result raised outside the final step");

   // The held level never leaves the percentage range.
   assert property (@(posedge clock) disable iff (reset)
      level_ff <= ble_pkg::PCT_FULL)
      else $error("reported level above full scale");

endmodule

`default_nettype wire
